// File: rtl/core/fdf_pkg.sv
// Shared constants, reciprocal table and control structs for the
// fractional differencing filter. No dependencies.
package fdf_pkg;

    localparam int MAX_TAPS   = 64;
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int CNT_W      = $clog2(MAX_TAPS + 1);

    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 32;
    localparam int OUT_W      = 48;
    localparam int TAPS_W     = 7;
    localparam int ORDER_W    = 15;
    localparam int CUTOFF_W   = 30;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;
    localparam int RECIP_W    = 31;
    localparam int D_SHIFT    = 14;

    localparam logic [CFG_IDX_W-1:0] REG_FRAC_ORDER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CUTOFF = 1'b1;

    localparam logic [ORDER_W-1:0]  ORDER_RESET  = 15'd8192;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 30'd10737;
    localparam logic signed [WEIGHT_W-1:0] ONE_Q30 = 32'sh4000_0000;

    typedef logic [RECIP_W-1:0] recip_tab_t [MAX_TAPS+1];

    // round(2^30 / k), entry 0 unused
    function automatic recip_tab_t build_recip();
        recip_tab_t tab;
        tab[0] = '0;
        for (int i = 1; i <= MAX_TAPS; i++)
        begin
            tab[i] = RECIP_W'(((64'd1 << 30) + 64'(i / 2)) / 64'(i));
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip();

    typedef struct packed {
        logic             take;
        logic             wt_init;
        logic             bld_mul1;
        logic             bld_rnd;
        logic             bld_mul2;
        logic             bld_sat;
        logic             wt_write;
        logic             hist_push;
        logic             acc_clear;
        logic             mac_issue;
        logic [IDX_W-1:0] mac_idx;
        logic [CNT_W-1:0] taps;
        logic             trunc;
        logic             load_out;
    } fdf_cmd_t;

    typedef struct packed {
        logic cand_small;
        logic mac_busy;
    } fdf_stat_t;

endpackage

// File: rtl/core/fdf_if.sv
// Valid/ready channel interfaces for samples and filter results.
// Depends on fdf_pkg.
interface fdf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fdf_pkg::SAMPLE_W-1:0]  sample;
    logic                                 series_start;

    modport source (output valid, output sample, output series_start, input ready);
    modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface fdf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fdf_pkg::OUT_W-1:0]     diff_value;
    logic [fdf_pkg::TAPS_W-1:0]           window_taps;
    logic                                 taps_truncated;

    modport source (output valid, output diff_value, output window_taps,
                    output taps_truncated, input ready);
    modport sink   (input valid, input diff_value, input window_taps,
                    input taps_truncated, output ready);
endinterface

// File: rtl/core/fdf_datapath.sv
// Datapath: configuration registers, weight builder, weight and history
// memories, shared multiply-accumulate and output register. Uses fdf_pkg.
module fdf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fdf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [fdf_pkg::SAMPLE_W-1:0] sample,
    input  fdf_pkg::fdf_cmd_t                   cmd,
    output fdf_pkg::fdf_stat_t                  stat,
    output logic signed [fdf_pkg::OUT_W-1:0]    diff_value,
    output logic [fdf_pkg::TAPS_W-1:0]          window_taps,
    output logic                                taps_truncated
);
    import fdf_pkg::*;

    localparam int NUM_W = CNT_W + ORDER_W + 1;
    localparam int P1_W  = NUM_W + 32;
    localparam int F_W   = 33;
    localparam int P2_W  = WEIGHT_W + F_W + 1;
    localparam int ACC_W = 2 * SAMPLE_W + IDX_W;

    logic [ORDER_W-1:0]         order_reg;
    logic [CUTOFF_W-1:0]        cutoff_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic signed [WEIGHT_W-1:0] w_prev_reg;
    logic signed [P1_W-1:0]     p1_reg;
    logic signed [F_W-1:0]      f_reg;
    logic signed [P2_W-1:0]     p2_reg;
    logic signed [WEIGHT_W-1:0] cand_reg;

    logic signed [WEIGHT_W-1:0] weight_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic [IDX_W-1:0]           head_reg;
    logic [IDX_W-1:0]           head_next;

    logic signed [WEIGHT_W-1:0]   wt_rd_reg;
    logic signed [SAMPLE_W-1:0]   hist_rd_reg;
    logic signed [2*SAMPLE_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic                         v1_reg;
    logic                         v2_reg;

    logic signed [OUT_W-1:0]    diff_value_reg;
    logic [TAPS_W-1:0]          window_taps_reg;
    logic                       taps_truncated_reg;

    logic signed [NUM_W-1:0]    num;
    logic signed [P1_W-1:0]     p1_rnd;
    logic signed [P2_W-1:0]     p2_rnd;
    logic signed [P2_W-1:0]     q2;
    logic signed [P2_W-1:0]     w_new;
    logic signed [WEIGHT_W-1:0] w_sat;
    logic [WEIGHT_W:0]          cand_mag;
    logic [IDX_W:0]             hist_diff;
    logic [IDX_W-1:0]           hist_addr;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [OUT_W-1:0]    out_sat;

    // weight recursion arithmetic
    always_comb
    begin
        num    = NUM_W'(order_reg) - (NUM_W'(cmd.taps - CNT_W'(1)) << D_SHIFT);
        p1_rnd = p1_reg + (p1_reg < 0 ? P1_W'((1 << (D_SHIFT - 1)) - 1)
                                      : P1_W'(1 << (D_SHIFT - 1)));
        p2_rnd = p2_reg + (p2_reg < 0 ? P2_W'((1 << 29) - 1) : P2_W'(1 << 29));
        q2     = p2_rnd >>> 30;
        w_new  = -q2;
        if (w_new > P2_W'(32'sh7FFF_FFFF))
            w_sat = 32'sh7FFF_FFFF;
        else if (w_new < -P2_W'(64'sh8000_0000))
            w_sat = 32'sh8000_0000;
        else
            w_sat = WEIGHT_W'(w_new);
        cand_mag = cand_reg[WEIGHT_W-1] ? ((WEIGHT_W+1)'(0) - {1'b1, cand_reg})
                                        : {1'b0, cand_reg};
    end

    assign stat.cand_small = cand_mag < (WEIGHT_W+1)'(cutoff_reg);
    assign stat.mac_busy   = v1_reg | v2_reg;

    // newest sample sits at head; tap k lives k entries behind it
    always_comb
    begin
        head_next = (head_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : head_reg + IDX_W'(1);
        hist_diff = {1'b0, head_reg} - {1'b0, cmd.mac_idx};
        if (hist_diff[IDX_W])
            hist_addr = IDX_W'(hist_diff + (IDX_W+1)'(MAX_TAPS));
        else
            hist_addr = IDX_W'(hist_diff);
    end

    always_comb
    begin
        acc_rnd = (acc_reg + ACC_W'(1 << 29)) >>> 30;
        if (acc_rnd > ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1))
            out_sat = {1'b0, {(OUT_W-1){1'b1}}};
        else if (acc_rnd < -(ACC_W'(64'sd1 <<< (OUT_W - 1))))
            out_sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            out_sat = OUT_W'(acc_rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= ORDER_RESET;
            cutoff_reg <= CUTOFF_RESET;
            head_reg   <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAC_ORDER:    order_reg  <= cfg_data[ORDER_W-1:0];
                    REG_WEIGHT_CUTOFF: cutoff_reg <= cfg_data[CUTOFF_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.hist_push)
                head_reg <= head_next;
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            sample_reg <= sample;
        if (cmd.wt_init)
            w_prev_reg <= ONE_Q30;
        else if (cmd.wt_write)
            w_prev_reg <= cand_reg;
        if (cmd.bld_mul1)
            p1_reg <= num * $signed({1'b0, RECIP_TAB[cmd.taps]});
        if (cmd.bld_rnd)
            f_reg <= F_W'(p1_rnd >>> D_SHIFT);
        if (cmd.bld_mul2)
            p2_reg <= w_prev_reg * f_reg;
        if (cmd.bld_sat)
            cand_reg <= w_sat;

        if (cmd.wt_init)
            weight_mem[0] <= ONE_Q30;
        else if (cmd.wt_write)
            weight_mem[cmd.taps[IDX_W-1:0]] <= cand_reg;
        if (cmd.hist_push)
            hist_mem[head_next] <= sample_reg;
        if (cmd.mac_issue)
        begin
            wt_rd_reg   <= weight_mem[cmd.mac_idx];
            hist_rd_reg <= hist_mem[hist_addr];
        end

        if (v1_reg)
            prod_reg <= wt_rd_reg * hist_rd_reg;
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);

        if (cmd.load_out)
        begin
            diff_value_reg     <= out_sat;
            window_taps_reg    <= TAPS_W'(cmd.taps);
            taps_truncated_reg <= cmd.trunc;
        end
    end

    assign diff_value     = diff_value_reg;
    assign window_taps    = window_taps_reg;
    assign taps_truncated = taps_truncated_reg;

endmodule

// File: rtl/core/fdf_ctrl.sv
// Controller: sequences weight building, history push and the tap walk.
// Holds tap, fill and truncation state. Uses fdf_pkg.
module fdf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_series_start,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output fdf_pkg::fdf_cmd_t  cmd,
    input  fdf_pkg::fdf_stat_t stat
);
    import fdf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLD_INIT,
        S_BLD_MUL1,
        S_BLD_RND,
        S_BLD_MUL2,
        S_BLD_SAT,
        S_BLD_CHK,
        S_HIST,
        S_MAC,
        S_DRAIN,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] tap_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             trunc_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign fill_next = (fill_reg < tap_reg) ? fill_reg + CNT_W'(1) : fill_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.mac_idx   = idx_reg;
        cmd.taps      = tap_reg;
        cmd.trunc     = trunc_reg;
        case (state_reg)
            S_IDLE:     cmd.take      = in_valid;
            S_BLD_INIT: cmd.wt_init   = 1'b1;
            S_BLD_MUL1: cmd.bld_mul1  = 1'b1;
            S_BLD_RND:  cmd.bld_rnd   = 1'b1;
            S_BLD_MUL2: cmd.bld_mul2  = 1'b1;
            S_BLD_SAT:  cmd.bld_sat   = 1'b1;
            S_BLD_CHK:  cmd.wt_write  = !stat.cand_small && (tap_reg < CNT_W'(MAX_TAPS));
            S_HIST:
            begin
                cmd.hist_push = (tap_reg != '0);
                cmd.acc_clear = 1'b1;
            end
            S_MAC:      cmd.mac_issue = 1'b1;
            S_OUT:      cmd.load_out  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            fill_reg      <= '0;
            trunc_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= in_series_start ? S_BLD_INIT : S_HIST;
                end
                S_BLD_INIT:
                begin
                    tap_reg   <= CNT_W'(1);
                    fill_reg  <= '0;
                    trunc_reg <= 1'b0;
                    state_reg <= S_BLD_MUL1;
                end
                S_BLD_MUL1: state_reg <= S_BLD_RND;
                S_BLD_RND:  state_reg <= S_BLD_MUL2;
                S_BLD_MUL2: state_reg <= S_BLD_SAT;
                S_BLD_SAT:  state_reg <= S_BLD_CHK;
                S_BLD_CHK:
                begin
                    if (stat.cand_small)
                        state_reg <= S_HIST;
                    else if (tap_reg >= CNT_W'(MAX_TAPS))
                    begin
                        trunc_reg <= 1'b1;
                        state_reg <= S_HIST;
                    end
                    else
                    begin
                        tap_reg   <= tap_reg + CNT_W'(1);
                        state_reg <= S_BLD_MUL1;
                    end
                end
                S_HIST:
                begin
                    // drop samples until a series has been started
                    if (tap_reg == '0)
                        state_reg <= S_IDLE;
                    else
                    begin
                        fill_reg <= fill_next;
                        idx_reg  <= '0;
                        state_reg <= (fill_next < tap_reg) ? S_IDLE : S_MAC;
                    end
                end
                S_MAC:
                begin
                    if (CNT_W'(idx_reg) == tap_reg - CNT_W'(1))
                        state_reg <= S_DRAIN;
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                S_DRAIN:
                begin
                    if (!stat.mac_busy)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/fractional_difference_filter.sv
// Top level of the fractional differencing filter: controller plus datapath.
// Depends on fdf_pkg, fdf_if, fdf_ctrl and fdf_datapath.
//
//  port     dir  handshake          payload
//  in_ch    in   valid/ready        sample, series_start
//  out_ch   out  valid/ready        diff_value, window_taps, taps_truncated
//  cfg      in   cfg_we             cfg_index, cfg_data
//
// With W taps in use a sample is accepted, written to the history, walked
// one tap per cycle through the shared multiply-accumulate, drained and
// loaded into the output register. A window-filling sample skips the walk.
// An item with series_start first rebuilds the weights, one tap at a time.
// Reset clears control and config registers only; no memory clear is needed.
// A pending result waits in the output register; the next item is taken
// meanwhile and stalls only when its own result is ready.
module fractional_difference_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    fdf_in_if.sink                           in_ch,
    fdf_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [fdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fdf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fdf_pkg::*;

    fdf_cmd_t  cmd;
    fdf_stat_t stat;

    fdf_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_series_start (in_ch.series_start),
        .in_ready        (in_ch.ready),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .cmd             (cmd),
        .stat            (stat)
    );

    fdf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (in_ch.sample),
        .cmd            (cmd),
        .stat           (stat),
        .diff_value     (out_ch.diff_value),
        .window_taps    (out_ch.window_taps),
        .taps_truncated (out_ch.taps_truncated)
    );

endmodule
